### rtl/core/npg_pkg.sv
`timescale 1ns / 1ps

package npg_pkg;

	// Capacity of the word and the widths that follow from it.
	localparam int MAX_SYMBOLS = 16;
	localparam int IDX_W = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;
	localparam int LEN_W = $clog2(MAX_SYMBOLS + 1);
	localparam int SYM_W = 8;
	localparam int POS_W = 6;

	typedef logic [LEN_W-1:0] len_t;
	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [SYM_W-1:0] sym_t;

	localparam len_t LEN_MAX = LEN_W'(MAX_SYMBOLS);

	// Request codes carried by an input item.
	typedef enum logic [1:0] {
		REQ_CLEAR   = 2'd0,
		REQ_LOAD    = 2'd1,
		REQ_EMIT    = 2'd2,
		REQ_ADVANCE = 2'd3
	} req_code_t;

	// Sequencer states.
	typedef enum logic [4:0] {
		ST_IDLE,
		ST_LD_RD,
		ST_LD_CMP,
		ST_LD_SH,
		ST_LD_WR,
		ST_EM_RD,
		ST_EM_OUT,
		ST_EXH,
		ST_PV_RD0,
		ST_PV_LD0,
		ST_PV_RD,
		ST_PV_CMP,
		ST_SU_RD,
		ST_SU_CMP,
		ST_SU_WR,
		ST_RV_CHK,
		ST_RV_RA,
		ST_RV_RB,
		ST_RV_WA,
		ST_RV_WB
	} state_t;

endpackage

### rtl/core/npg_req_if.sv
`timescale 1ns / 1ps

interface npg_req_if import npg_pkg::*; ();
	logic       valid;
	logic       ready;
	logic [1:0] req_type;
	sym_t       symbol;

	modport source (output valid, output req_type, output symbol, input ready);
	modport sink (input valid, input req_type, input symbol, output ready);
endinterface

### rtl/core/npg_res_if.sv
`timescale 1ns / 1ps

interface npg_res_if import npg_pkg::*; ();
	logic             valid;
	logic             ready;
	sym_t             out_symbol;
	logic [POS_W-1:0] position;
	logic             last_of_run;
	logic             exhausted;
	logic             overflowed;

	modport source (
		output valid, output out_symbol, output position, output last_of_run,
		output exhausted, output overflowed, input ready
	);
	modport sink (
		input valid, input out_symbol, input position, input last_of_run,
		input exhausted, input overflowed, output ready
	);
endinterface

### rtl/core/next_permutation_generator.sv
`timescale 1ns / 1ps
// Clear and a load at capacity are handled in the idle state; a load scans for the insertion point,
// shifts the tail up and inserts. Emit reads and sends one symbol at a time; an advance runs the
// pivot scan, the successor scan and a suffix reversal that swaps one pair at a time.
// One item at a time: the word memory has a single read port and there is one shared
// comparator. Reset clears length, overflow flag, result valid and sequencer state.
module next_permutation_generator import npg_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	npg_req_if.sink  req,
	npg_res_if.source res
);

	// Word memory with one write and one registered read port.
	sym_t   mem [MAX_SYMBOLS];
	logic   rd_en;
	idx_t   raddr;
	sym_t   rdata_q;
	logic   we;
	idx_t   waddr;
	sym_t   wdata;

	// Sequencer state and working registers.
	state_t state_q, state_d;
	len_t   len_q, len_d;
	logic   ovf_q, ovf_d;
	len_t   k_q, k_d;
	len_t   j_q, j_d;
	sym_t   a_q, a_d;
	sym_t   sym_q, sym_d;
	logic   rv_exh_q, rv_exh_d;

	// Result register.
	logic             o_valid_q, o_valid_d;
	sym_t             o_sym_q, o_sym_d;
	logic [POS_W-1:0] o_pos_q, o_pos_d;
	logic             o_last_q, o_last_d;
	logic             o_exh_q, o_exh_d;
	logic             o_ovf_q, o_ovf_d;
	logic             out_free;
	logic             out_load;

	// Shared comparator and derived counts.
	sym_t           cmp_x, cmp_y;
	logic           cmp_lt;
	len_t           k_m1, j_m1;
	logic [LEN_W:0] k_p1;

	assign cmp_lt = cmp_x < cmp_y;
	assign k_m1 = k_q - 1'b1;
	assign j_m1 = j_q - 1'b1;
	assign k_p1 = {1'b0, k_q} + 1'b1;
	assign out_free = !o_valid_q || res.ready;

	assign req.ready = (state_q == ST_IDLE);
	assign res.valid = o_valid_q;
	assign res.out_symbol = o_sym_q;
	assign res.position = o_pos_q;
	assign res.last_of_run = o_last_q;
	assign res.exhausted = o_exh_q;
	assign res.overflowed = o_ovf_q;

	// Memory write and registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (rd_en) begin
			rdata_q <= mem[raddr];
		end
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			len_q <= '0;
			ovf_q <= 1'b0;
			o_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			len_q <= len_d;
			ovf_q <= ovf_d;
			o_valid_q <= o_valid_d;
		end
	end

	// Working and payload registers.
	always_ff @(posedge clk) begin
		k_q <= k_d;
		j_q <= j_d;
		a_q <= a_d;
		sym_q <= sym_d;
		rv_exh_q <= rv_exh_d;
		o_sym_q <= o_sym_d;
		o_pos_q <= o_pos_d;
		o_last_q <= o_last_d;
		o_exh_q <= o_exh_d;
		o_ovf_q <= o_ovf_d;
	end

	// Next state, memory control and result loading.
	always_comb begin
		state_d = state_q;
		len_d = len_q;
		ovf_d = ovf_q;
		k_d = k_q;
		j_d = j_q;
		a_d = a_q;
		sym_d = sym_q;
		rv_exh_d = rv_exh_q;
		rd_en = 1'b0;
		raddr = k_q[IDX_W-1:0];
		we = 1'b0;
		waddr = k_q[IDX_W-1:0];
		wdata = rdata_q;
		cmp_x = rdata_q;
		cmp_y = a_q;
		out_load = 1'b0;
		o_sym_d = o_sym_q;
		o_pos_d = o_pos_q;
		o_last_d = o_last_q;
		o_exh_d = o_exh_q;
		o_ovf_d = o_ovf_q;

		unique case (state_q)
			ST_IDLE: begin
				if (req.valid) begin
					sym_d = req.symbol;
					unique case (req_code_t'(req.req_type))
						REQ_CLEAR: begin
							len_d = '0;
							ovf_d = 1'b0;
						end
						REQ_LOAD: begin
							if (len_q >= LEN_MAX) begin
								ovf_d = 1'b1;
							end else begin
								k_d = '0;
								state_d = ST_LD_RD;
							end
						end
						REQ_EMIT: begin
							k_d = '0;
							state_d = (len_q == '0) ? ST_EXH : ST_EM_RD;
						end
						REQ_ADVANCE: begin
							k_d = len_q - 1'b1;
							state_d = (len_q < LEN_W'(2)) ? ST_EXH : ST_PV_RD0;
						end
						default: begin
							state_d = ST_IDLE;
						end
					endcase
				end
			end

			// Load: find the first stored symbol greater than the new one.
			ST_LD_RD: begin
				if (k_q == len_q) begin
					j_d = len_q;
					state_d = ST_LD_SH;
				end else begin
					rd_en = 1'b1;
					state_d = ST_LD_CMP;
				end
			end
			ST_LD_CMP: begin
				cmp_x = sym_q;
				cmp_y = rdata_q;
				if (cmp_lt) begin
					j_d = len_q;
					state_d = ST_LD_SH;
				end else begin
					k_d = k_p1[LEN_W-1:0];
					state_d = ST_LD_RD;
				end
			end

			// Load: shift the tail up one place, then insert.
			ST_LD_SH: begin
				if (j_q == k_q) begin
					we = 1'b1;
					waddr = k_q[IDX_W-1:0];
					wdata = sym_q;
					len_d = len_q + 1'b1;
					state_d = ST_IDLE;
				end else begin
					rd_en = 1'b1;
					raddr = j_m1[IDX_W-1:0];
					state_d = ST_LD_WR;
				end
			end
			ST_LD_WR: begin
				we = 1'b1;
				waddr = j_q[IDX_W-1:0];
				wdata = rdata_q;
				j_d = j_m1;
				state_d = ST_LD_SH;
			end

			// Emit the word one symbol at a time.
			ST_EM_RD: begin
				rd_en = 1'b1;
				state_d = ST_EM_OUT;
			end
			ST_EM_OUT: begin
				if (out_free) begin
					out_load = 1'b1;
					o_sym_d = rdata_q;
					o_pos_d = POS_W'(k_q);
					o_last_d = (k_p1 == {1'b0, len_q});
					o_exh_d = 1'b0;
					o_ovf_d = ovf_q;
					k_d = k_p1[LEN_W-1:0];
					state_d = (k_p1 == {1'b0, len_q}) ? ST_IDLE : ST_EM_RD;
				end
			end

			// Single exhausted result.
			ST_EXH: begin
				if (out_free) begin
					out_load = 1'b1;
					o_sym_d = '0;
					o_pos_d = '0;
					o_last_d = 1'b1;
					o_exh_d = 1'b1;
					o_ovf_d = ovf_q;
					state_d = ST_IDLE;
				end
			end

			// Pivot scan from the right; a_q holds the symbol to the right.
			ST_PV_RD0: begin
				rd_en = 1'b1;
				state_d = ST_PV_LD0;
			end
			ST_PV_LD0: begin
				a_d = rdata_q;
				state_d = ST_PV_RD;
			end
			ST_PV_RD: begin
				if (k_q == '0) begin
					j_d = len_q;
					rv_exh_d = 1'b1;
					state_d = ST_RV_CHK;
				end else begin
					rd_en = 1'b1;
					raddr = k_m1[IDX_W-1:0];
					state_d = ST_PV_CMP;
				end
			end
			ST_PV_CMP: begin
				cmp_x = rdata_q;
				cmp_y = a_q;
				a_d = rdata_q;
				if (cmp_lt) begin
					j_d = len_q - 1'b1;
					state_d = ST_SU_RD;
				end else begin
					k_d = k_m1;
					state_d = ST_PV_RD;
				end
			end

			// Successor scan from the right; a_q now holds the pivot symbol.
			ST_SU_RD: begin
				rd_en = 1'b1;
				raddr = j_q[IDX_W-1:0];
				state_d = ST_SU_CMP;
			end
			ST_SU_CMP: begin
				cmp_x = a_q;
				cmp_y = rdata_q;
				if (cmp_lt) begin
					we = 1'b1;
					waddr = k_m1[IDX_W-1:0];
					wdata = rdata_q;
					state_d = ST_SU_WR;
				end else begin
					j_d = j_m1;
					state_d = ST_SU_RD;
				end
			end
			ST_SU_WR: begin
				we = 1'b1;
				waddr = j_q[IDX_W-1:0];
				wdata = a_q;
				j_d = len_q;
				rv_exh_d = 1'b0;
				state_d = ST_RV_CHK;
			end

			// Reverse the range from k_q up to but not including j_q.
			ST_RV_CHK: begin
				if (k_p1 < {1'b0, j_q}) begin
					state_d = ST_RV_RA;
				end else if (rv_exh_q) begin
					state_d = ST_EXH;
				end else begin
					k_d = '0;
					state_d = ST_EM_RD;
				end
			end
			ST_RV_RA: begin
				rd_en = 1'b1;
				state_d = ST_RV_RB;
			end
			ST_RV_RB: begin
				rd_en = 1'b1;
				raddr = j_m1[IDX_W-1:0];
				a_d = rdata_q;
				state_d = ST_RV_WA;
			end
			ST_RV_WA: begin
				we = 1'b1;
				waddr = k_q[IDX_W-1:0];
				wdata = rdata_q;
				state_d = ST_RV_WB;
			end
			ST_RV_WB: begin
				we = 1'b1;
				waddr = j_m1[IDX_W-1:0];
				wdata = a_q;
				k_d = k_p1[LEN_W-1:0];
				j_d = j_m1;
				state_d = ST_RV_CHK;
			end

			default: begin
				state_d = ST_IDLE;
			end
		endcase

		// The result register empties when taken and fills when loaded.
		if (out_load) begin
			o_valid_d = 1'b1;
		end else if (res.ready) begin
			o_valid_d = 1'b0;
		end else begin
			o_valid_d = o_valid_q;
		end
	end

endmodule
